// ----- rtl/blbs_pkg.sv -----
package blbs_pkg;

    // canvas and brush limits
    localparam int MAX_CANVAS = 1024;
    localparam int MAX_BRUSH  = 15;

    // fixed field widths
    localparam int COORD_IN_W  = 11;
    localparam int COORD_W     = 12;
    localparam int ERR_W       = 14;
    localparam int DELTA_W     = 11;
    localparam int CANVAS_W    = 11;
    localparam int BRUSH_W     = 4;
    localparam int MATERIAL_W  = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // reset values of the configuration registers
    localparam logic [CANVAS_W-1:0]   CANVAS_WIDTH_RST  = CANVAS_W'(256);
    localparam logic [CANVAS_W-1:0]   CANVAS_HEIGHT_RST = CANVAS_W'(256);
    localparam logic [BRUSH_W-1:0]    BRUSH_WIDTH_RST   = BRUSH_W'(3);
    localparam logic [MATERIAL_W-1:0] MATERIAL_RST      = MATERIAL_W'(0);

    // material code that means erase
    localparam logic [MATERIAL_W-1:0] MATERIAL_ERASE = MATERIAL_W'(0);

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_CANVAS_WIDTH   = 2'd0,
        REG_CANVAS_HEIGHT  = 2'd1,
        REG_BRUSH_WIDTH    = 2'd2,
        REG_BRUSH_MATERIAL = 2'd3
    } cfg_idx_t;

endpackage

// ----- rtl/bresenham_line_brush_stamper.sv -----
// Bresenham line brush stamper. A load transfer (op = 0) latches a segment and
// returns nothing; every step transfer (op = 1) returns one pixel of a square
// brush stamped at each point of the line, brush column outer and row inner,
// with an out-of-bounds flag instead of clipping. The block takes one item per
// cycle: all per-step work (brush offset add, bounds compare, error update) is
// one combinational pass from the segment registers into the output and
// segment registers, so a result appears in the cycle after its step
// transfer and input is taken while that result waits, as long as the output
// register is drained in the same cycle. A step with no segment loaded returns
// a zero pixel marked done. Configuration writes are accepted in every cycle.
module bresenham_line_brush_stamper
    import blbs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic signed [COORD_IN_W-1:0] start_x,
    input  logic signed [COORD_IN_W-1:0] start_y,
    input  logic signed [COORD_IN_W-1:0] end_x,
    input  logic signed [COORD_IN_W-1:0] end_y,

    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_W-1:0]    pixel_x,
    output logic signed [COORD_W-1:0]    pixel_y,
    output logic                         in_bounds,
    output logic                         erase,
    output logic [MATERIAL_W-1:0]        material,
    output logic                         segment_done
);

    // configuration registers
    logic [CANVAS_W-1:0]   canvas_width_reg;
    logic [CANVAS_W-1:0]   canvas_height_reg;
    logic [BRUSH_W-1:0]    brush_width_reg;
    logic [MATERIAL_W-1:0] brush_material_reg;

    // segment state
    logic signed [COORD_W-1:0] cur_x_reg,     cur_x_next;
    logic signed [COORD_W-1:0] cur_y_reg,     cur_y_next;
    logic signed [COORD_W-1:0] major_end_reg, major_end_next;
    logic signed [ERR_W-1:0]   err_reg,       err_next;
    logic [DELTA_W-1:0]        abs_dx_reg,    abs_dx_next;
    logic [DELTA_W-1:0]        abs_dy_reg,    abs_dy_next;
    logic                      x_major_reg,   x_major_next;
    logic                      minor_down_reg, minor_down_next;
    logic [BRUSH_W-1:0]        brush_col_reg, brush_col_next;
    logic [BRUSH_W-1:0]        brush_row_reg, brush_row_next;
    logic                      active_reg,    active_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] pixel_x_reg,   pixel_x_next;
    logic signed [COORD_W-1:0] pixel_y_reg,   pixel_y_next;
    logic                      in_bounds_reg, in_bounds_next;
    logic                      erase_reg,     erase_next;
    logic [MATERIAL_W-1:0]     material_reg,  material_next;
    logic                      done_reg,      done_next;

    logic accept;

    // load path signals
    logic signed [COORD_W-1:0] sx, sy, ex, ey, dx, dy, ndx, ndy;
    logic [DELTA_W-1:0]        ld_adx, ld_ady;

    // step path signals
    logic [BRUSH_W-1:0]        brush_eff, brush_m1;
    logic [BRUSH_W-2:0]        brush_half;
    logic [CANVAS_W-1:0]       w_eff, h_eff;
    logic signed [COORD_W-1:0] px, py;
    logic                      px_in, py_in;
    logic                      last_brush, at_end;
    logic signed [ERR_W-1:0]   two_adx, two_ady;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg   <= CANVAS_WIDTH_RST;
            canvas_height_reg  <= CANVAS_HEIGHT_RST;
            brush_width_reg    <= BRUSH_WIDTH_RST;
            brush_material_reg <= MATERIAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CANVAS_WIDTH:   canvas_width_reg   <= cfg_data[CANVAS_W-1:0];
                REG_CANVAS_HEIGHT:  canvas_height_reg  <= cfg_data[CANVAS_W-1:0];
                REG_BRUSH_WIDTH:    brush_width_reg    <= cfg_data[BRUSH_W-1:0];
                REG_BRUSH_MATERIAL: brush_material_reg <= cfg_data[MATERIAL_W-1:0];
            endcase
        end
    end

    // endpoint deltas for a load
    always_comb
    begin
        sx  = COORD_W'(start_x);
        sy  = COORD_W'(start_y);
        ex  = COORD_W'(end_x);
        ey  = COORD_W'(end_y);
        dx  = ex - sx;
        dy  = ey - sy;
        ndx = -dx;
        ndy = -dy;
        ld_adx = dx[COORD_W-1] ? ndx[DELTA_W-1:0] : dx[DELTA_W-1:0];
        ld_ady = dy[COORD_W-1] ? ndy[DELTA_W-1:0] : dy[DELTA_W-1:0];
    end

    // brush geometry and bounds for the current pixel
    always_comb
    begin
        if (brush_width_reg == '0)
            brush_eff = BRUSH_W'(1);
        else if (brush_width_reg > BRUSH_W'(MAX_BRUSH))
            brush_eff = BRUSH_W'(MAX_BRUSH);
        else
            brush_eff = brush_width_reg;
        brush_m1   = brush_eff - BRUSH_W'(1);
        brush_half = brush_m1[BRUSH_W-1:1];

        w_eff = (canvas_width_reg  > CANVAS_W'(MAX_CANVAS)) ? CANVAS_W'(MAX_CANVAS)
                                                            : canvas_width_reg;
        h_eff = (canvas_height_reg > CANVAS_W'(MAX_CANVAS)) ? CANVAS_W'(MAX_CANVAS)
                                                            : canvas_height_reg;

        px = cur_x_reg + COORD_W'(brush_col_reg) - COORD_W'(brush_half);
        py = cur_y_reg + COORD_W'(brush_row_reg) - COORD_W'(brush_half);
        px_in = !px[COORD_W-1] && ($unsigned(px) < {1'b0, w_eff});
        py_in = !py[COORD_W-1] && ($unsigned(py) < {1'b0, h_eff});

        last_brush = (brush_col_reg >= brush_m1) && (brush_row_reg >= brush_m1);
        at_end     = (x_major_reg ? cur_x_reg : cur_y_reg) >= major_end_reg;

        two_adx = ERR_W'({abs_dx_reg, 1'b0});
        two_ady = ERR_W'({abs_dy_reg, 1'b0});
    end

    // next segment state and result
    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        major_end_next  = major_end_reg;
        err_next        = err_reg;
        abs_dx_next     = abs_dx_reg;
        abs_dy_next     = abs_dy_reg;
        x_major_next    = x_major_reg;
        minor_down_next = minor_down_reg;
        brush_col_next  = brush_col_reg;
        brush_row_next  = brush_row_reg;
        active_next     = active_reg;

        out_valid_next = out_valid_reg && !out_ready;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        in_bounds_next = in_bounds_reg;
        erase_next     = erase_reg;
        material_next  = material_reg;
        done_next      = done_reg;

        if (accept)
        begin
            unique case (op_t'(op))
                OP_LOAD:
                begin
                    out_valid_next  = 1'b0;
                    abs_dx_next     = ld_adx;
                    abs_dy_next     = ld_ady;
                    minor_down_next = !((dx[COORD_W-1] && dy[COORD_W-1]) ||
                                        (dx > 0 && dy > 0));
                    brush_col_next  = '0;
                    brush_row_next  = '0;
                    active_next     = 1'b1;
                    if (ld_ady <= ld_adx)
                    begin
                        x_major_next = 1'b1;
                        err_next     = ERR_W'({ld_ady, 1'b0}) - ERR_W'(ld_adx);
                        if (!dx[COORD_W-1])
                        begin
                            cur_x_next     = sx;
                            cur_y_next     = sy;
                            major_end_next = ex;
                        end
                        else
                        begin
                            cur_x_next     = ex;
                            cur_y_next     = ey;
                            major_end_next = sx;
                        end
                    end
                    else
                    begin
                        x_major_next = 1'b0;
                        err_next     = ERR_W'({ld_adx, 1'b0}) - ERR_W'(ld_ady);
                        if (!dy[COORD_W-1])
                        begin
                            cur_x_next     = sx;
                            cur_y_next     = sy;
                            major_end_next = ey;
                        end
                        else
                        begin
                            cur_x_next     = ex;
                            cur_y_next     = ey;
                            major_end_next = sy;
                        end
                    end
                end

                OP_STEP:
                begin
                    out_valid_next = 1'b1;
                    if (!active_reg)
                    begin
                        // no segment: zero pixel flagged done
                        pixel_x_next   = '0;
                        pixel_y_next   = '0;
                        in_bounds_next = 1'b0;
                        erase_next     = 1'b0;
                        material_next  = '0;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        pixel_x_next   = px;
                        pixel_y_next   = py;
                        in_bounds_next = px_in && py_in;
                        erase_next     = (brush_material_reg == MATERIAL_ERASE);
                        material_next  = brush_material_reg;
                        done_next      = last_brush && at_end;

                        // walk the brush, then the line
                        if (!last_brush)
                        begin
                            if (brush_row_reg >= brush_m1)
                            begin
                                brush_row_next = '0;
                                brush_col_next = brush_col_reg + BRUSH_W'(1);
                            end
                            else
                            begin
                                brush_row_next = brush_row_reg + BRUSH_W'(1);
                            end
                        end
                        else
                        begin
                            brush_col_next = '0;
                            brush_row_next = '0;
                            if (at_end)
                            begin
                                active_next = 1'b0;
                            end
                            else if (x_major_reg)
                            begin
                                cur_x_next = cur_x_reg + COORD_W'(1);
                                if (err_reg[ERR_W-1])
                                begin
                                    err_next = err_reg + two_ady;
                                end
                                else
                                begin
                                    cur_y_next = minor_down_reg ? cur_y_reg - COORD_W'(1)
                                                                : cur_y_reg + COORD_W'(1);
                                    err_next   = err_reg + two_ady - two_adx;
                                end
                            end
                            else
                            begin
                                cur_y_next = cur_y_reg + COORD_W'(1);
                                if (err_reg <= 0)
                                begin
                                    err_next = err_reg + two_adx;
                                end
                                else
                                begin
                                    cur_x_next = minor_down_reg ? cur_x_reg - COORD_W'(1)
                                                                : cur_x_reg + COORD_W'(1);
                                    err_next   = err_reg + two_adx - two_ady;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    // control and segment registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            major_end_reg  <= '0;
            err_reg        <= '0;
            abs_dx_reg     <= '0;
            abs_dy_reg     <= '0;
            x_major_reg    <= 1'b0;
            minor_down_reg <= 1'b0;
            brush_col_reg  <= '0;
            brush_row_reg  <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            major_end_reg  <= major_end_next;
            err_reg        <= err_next;
            abs_dx_reg     <= abs_dx_next;
            abs_dy_reg     <= abs_dy_next;
            x_major_reg    <= x_major_next;
            minor_down_reg <= minor_down_next;
            brush_col_reg  <= brush_col_next;
            brush_row_reg  <= brush_row_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pixel_x_reg   <= pixel_x_next;
        pixel_y_reg   <= pixel_y_next;
        in_bounds_reg <= in_bounds_next;
        erase_reg     <= erase_next;
        material_reg  <= material_next;
        done_reg      <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign in_bounds    = in_bounds_reg;
    assign erase        = erase_reg;
    assign material     = material_reg;
    assign segment_done = done_reg;

endmodule

// ----- rtl/blbs_checker.sv -----
module blbs_props
    import blbs_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [CFG_IDX_W-1:0]         cfg_index,
    input logic [CFG_DATA_W-1:0]        cfg_data,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         op,
    input logic signed [COORD_IN_W-1:0] start_x,
    input logic signed [COORD_IN_W-1:0] start_y,
    input logic signed [COORD_IN_W-1:0] end_x,
    input logic signed [COORD_IN_W-1:0] end_y,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COORD_W-1:0]    pixel_x,
    input logic signed [COORD_W-1:0]    pixel_y,
    input logic                         in_bounds,
    input logic                         erase,
    input logic [MATERIAL_W-1:0]        material,
    input logic                         segment_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(in_bounds) && $stable(segment_done) && $stable(material))
        else $error("stalled result changed");

    // input side never blocked by an empty output register
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // every step transfer gives a result next cycle
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_STEP |=> out_valid)
        else $error("step transfer gave no result");

    // a load transfer gives no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_LOAD && (!out_valid || out_ready)
            |=> !out_valid)
        else $error("load transfer gave a result");

    // erase flag only with the erase material
    a_erase_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && erase |-> material == MATERIAL_ERASE)
        else $error("erase flagged with nonzero material");

endmodule

bind bresenham_line_brush_stamper blbs_props u_blbs_props (.*);
